@@ rtl/skt_pkg.sv @@
// Shared types and constants for the sorted key table.
`default_nettype none

package skt_pkg;

   localparam int KEY_W  = 31;
   localparam int NAME_W = 64;
   localparam int QTY_W  = 32;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_UPDATE = 2'd2,
      CMD_LIST   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_COMPARE,
      S_LOCATE,
      S_EXEC,
      S_EMIT,
      S_LIST
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic       latch_req;
      logic       cmp_en;
      logic       pos_en;
      logic       insert_en;
      logic       update_en;
      logic       idx_clear;
      logic       idx_inc;
      logic       load_out;
      logic       out_zero;
      logic       out_last;
      status_type out_status;
   } ctrl_type;

   // Datapath to controller status.
   typedef struct packed {
      cmd_type cmd;
      logic    hit;
      logic    full;
      logic    empty;
      logic    idx_last;
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/skt_if.sv @@
// Command and result channel interfaces for the sorted key table.
`default_nettype none

interface skt_req_if;
   logic                          valid;
   logic                          ready;
   skt_pkg::cmd_type              cmd;
   logic [skt_pkg::KEY_W-1:0]     part_number;
   logic [skt_pkg::NAME_W-1:0]    name_word;
   logic signed [skt_pkg::QTY_W-1:0] amount;

   modport source (output valid, cmd, part_number, name_word, amount, input ready);
   modport sink   (input valid, cmd, part_number, name_word, amount, output ready);
endinterface

interface skt_rsp_if;
   logic                          valid;
   logic                          ready;
   skt_pkg::status_type           status;
   logic [skt_pkg::KEY_W-1:0]     out_number;
   logic [skt_pkg::NAME_W-1:0]    out_name;
   logic signed [skt_pkg::QTY_W-1:0] out_quantity;
   logic                          last;

   modport source (output valid, status, out_number, out_name, out_quantity, last,
                   input ready);
   modport sink   (input valid, status, out_number, out_name, out_quantity, last,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/skt_datapath.sv @@
// Datapath of the sorted key table: entry cells, parallel compare, output register.
`default_nettype none

module skt_datapath #(
   parameter int TABLE_DEPTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire skt_pkg::cmd_type              req_cmd,
   input  wire logic [skt_pkg::KEY_W-1:0]     req_part_number,
   input  wire logic [skt_pkg::NAME_W-1:0]    req_name_word,
   input  wire logic signed [skt_pkg::QTY_W-1:0] req_amount,
   input  wire skt_pkg::ctrl_type             ctrl,
   output skt_pkg::dp_status_type             dp_status,
   output skt_pkg::status_type                rsp_status,
   output logic [skt_pkg::KEY_W-1:0]          rsp_out_number,
   output logic [skt_pkg::NAME_W-1:0]         rsp_out_name,
   output logic signed [skt_pkg::QTY_W-1:0]   rsp_out_quantity,
   output logic                               rsp_last
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // latched command
   skt_pkg::cmd_type               cmd_ff;
   logic [skt_pkg::KEY_W-1:0]      key_ff;
   logic [skt_pkg::NAME_W-1:0]     name_ff;
   logic signed [skt_pkg::QTY_W-1:0] amount_ff;

   // entry cells
   logic [skt_pkg::KEY_W-1:0]      key_cell_ff  [TABLE_DEPTH];
   logic [skt_pkg::NAME_W-1:0]     name_cell_ff [TABLE_DEPTH];
   logic signed [skt_pkg::QTY_W-1:0] qty_cell_ff [TABLE_DEPTH];
   logic [CNT_W-1:0]               count_ff;

   logic [TABLE_DEPTH-1:0]         lt_in, lt_ff;
   logic [TABLE_DEPTH-1:0]         eq_in;
   logic                           hit_ff;
   logic [TABLE_DEPTH:0]           edge_vec;
   logic [CNT_W-1:0]               pos_in;
   logic [CNT_W-1:0]               idx_ff;
   logic [IDX_W-1:0]               sel;

   logic signed [skt_pkg::QTY_W:0]   sum_wide;
   logic signed [skt_pkg::QTY_W-1:0] sum_sat;

   skt_pkg::status_type            status_ff;
   logic [skt_pkg::KEY_W-1:0]      number_ff;
   logic [skt_pkg::NAME_W-1:0]     name_out_ff;
   logic signed [skt_pkg::QTY_W-1:0] qty_out_ff;
   logic                           last_ff;

   assign sel = idx_ff[IDX_W-1:0];

   // parallel compare of every live cell against the key
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         lt_in[i] = (CNT_W'(i) < count_ff) && (key_cell_ff[i] < key_ff);
         eq_in[i] = (CNT_W'(i) < count_ff) && (key_cell_ff[i] == key_ff);
      end
   end

   // lt is a thermometer; its single falling edge marks the insert slot
   assign edge_vec = {lt_ff, 1'b1} & ~{1'b0, lt_ff};

   always_comb begin
      pos_in = '0;
      for (int i = 0; i <= TABLE_DEPTH; i++) begin
         if (edge_vec[i]) begin
            pos_in = pos_in | CNT_W'(i);
         end
      end
   end

   // saturating quantity update
   always_comb begin
      sum_wide = {qty_cell_ff[sel][skt_pkg::QTY_W-1], qty_cell_ff[sel]}
               + {amount_ff[skt_pkg::QTY_W-1], amount_ff};
      if (sum_wide[skt_pkg::QTY_W] != sum_wide[skt_pkg::QTY_W-1]) begin
         sum_sat = sum_wide[skt_pkg::QTY_W] ? {1'b1, {(skt_pkg::QTY_W-1){1'b0}}}
                                            : {1'b0, {(skt_pkg::QTY_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[skt_pkg::QTY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.latch_req) begin
         cmd_ff    <= req_cmd;
         key_ff    <= req_part_number;
         name_ff   <= req_name_word;
         amount_ff <= req_amount;
      end
      if (ctrl.cmp_en) begin
         lt_ff  <= lt_in;
         hit_ff <= |eq_in;
      end
      if (ctrl.pos_en) begin
         idx_ff <= pos_in;
      end else if (ctrl.idx_clear) begin
         idx_ff <= '0;
      end else if (ctrl.idx_inc) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
   end

   // cells: shift up above the slot on insert, rewrite the quantity on update
   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (ctrl.insert_en) begin
            if (CNT_W'(i) == idx_ff) begin
               key_cell_ff[i]  <= key_ff;
               name_cell_ff[i] <= name_ff;
               qty_cell_ff[i]  <= amount_ff;
            end else if (i > 0 && CNT_W'(i) > idx_ff && CNT_W'(i) <= count_ff) begin
               key_cell_ff[i]  <= key_cell_ff[(i > 0) ? i - 1 : 0];
               name_cell_ff[i] <= name_cell_ff[(i > 0) ? i - 1 : 0];
               qty_cell_ff[i]  <= qty_cell_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (ctrl.update_en && CNT_W'(i) == idx_ff) begin
            qty_cell_ff[i] <= sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.insert_en) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (ctrl.load_out) begin
         status_ff <= ctrl.out_status;
         last_ff   <= ctrl.out_last;
         if (ctrl.out_zero) begin
            number_ff   <= '0;
            name_out_ff <= '0;
            qty_out_ff  <= '0;
         end else begin
            number_ff   <= key_cell_ff[sel];
            name_out_ff <= name_cell_ff[sel];
            qty_out_ff  <= qty_cell_ff[sel];
         end
      end
   end

   assign dp_status.cmd      = cmd_ff;
   assign dp_status.hit      = hit_ff;
   assign dp_status.full     = (count_ff == CNT_W'(TABLE_DEPTH));
   assign dp_status.empty    = (count_ff == '0);
   assign dp_status.idx_last = (idx_ff == count_ff - CNT_W'(1));

   assign rsp_status       = status_ff;
   assign rsp_out_number   = number_ff;
   assign rsp_out_name     = name_out_ff;
   assign rsp_out_quantity = qty_out_ff;
   assign rsp_last         = last_ff;

endmodule

`default_nettype wire

@@ rtl/skt_controller.sv @@
// Command sequencer of the sorted key table.
`default_nettype none

module skt_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire skt_pkg::dp_status_type dp_status,
   output skt_pkg::ctrl_type          ctrl
);

   skt_pkg::state_type  state_ff, state_in;
   skt_pkg::status_type result_ff, result_in;
   logic                zero_ff, zero_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;
   logic                accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == skt_pkg::S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         skt_pkg::S_IDLE: begin
            // the command word comes straight from the port at the accept edge
            if (accept) begin
               state_in = (dp_status.cmd == skt_pkg::CMD_LIST)
                          ? skt_pkg::S_LIST : skt_pkg::S_COMPARE;
            end
         end
         skt_pkg::S_COMPARE: state_in = skt_pkg::S_LOCATE;
         skt_pkg::S_LOCATE:  state_in = skt_pkg::S_EXEC;
         skt_pkg::S_EXEC:    state_in = skt_pkg::S_EMIT;
         skt_pkg::S_EMIT: begin
            if (out_free) begin
               state_in = skt_pkg::S_IDLE;
            end
         end
         skt_pkg::S_LIST: begin
            if (out_free && (dp_status.empty || dp_status.idx_last)) begin
               state_in = skt_pkg::S_IDLE;
            end
         end
         default: state_in = skt_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl         = '0;
      result_in    = result_ff;
      zero_in      = zero_ff;
      ctrl.latch_req = accept;
      case (state_ff)
         skt_pkg::S_IDLE: begin
            ctrl.idx_clear = accept;
         end
         skt_pkg::S_COMPARE: begin
            ctrl.cmp_en = (dp_status.cmd != skt_pkg::CMD_LIST);
         end
         skt_pkg::S_LOCATE: begin
            ctrl.pos_en = 1'b1;
         end
         skt_pkg::S_EXEC: begin
            case (dp_status.cmd)
               skt_pkg::CMD_INSERT: begin
                  if (dp_status.full) begin
                     result_in = skt_pkg::ST_FULL;
                     zero_in   = 1'b1;
                  end else if (dp_status.hit) begin
                     result_in = skt_pkg::ST_DUPLICATE;
                     zero_in   = 1'b0;
                  end else begin
                     result_in      = skt_pkg::ST_OK;
                     zero_in        = 1'b0;
                     ctrl.insert_en = 1'b1;
                  end
               end
               skt_pkg::CMD_SEARCH, skt_pkg::CMD_UPDATE: begin
                  if (!dp_status.hit) begin
                     result_in = skt_pkg::ST_NOT_FOUND;
                     zero_in   = 1'b1;
                  end else begin
                     result_in      = skt_pkg::ST_OK;
                     zero_in        = 1'b0;
                     ctrl.update_en = (dp_status.cmd == skt_pkg::CMD_UPDATE);
                  end
               end
               default: begin
                  result_in = skt_pkg::ST_OK;
                  zero_in   = 1'b0;
               end
            endcase
         end
         skt_pkg::S_EMIT: begin
            ctrl.load_out   = out_free;
            ctrl.out_status = result_ff;
            ctrl.out_zero   = zero_ff;
            ctrl.out_last   = 1'b1;
         end
         skt_pkg::S_LIST: begin
            ctrl.load_out = out_free;
            if (dp_status.empty) begin
               ctrl.out_status = skt_pkg::ST_EMPTY;
               ctrl.out_zero   = 1'b1;
               ctrl.out_last   = 1'b1;
            end else begin
               ctrl.out_status = skt_pkg::ST_OK;
               ctrl.out_last   = dp_status.idx_last;
               ctrl.idx_inc    = out_free && !dp_status.idx_last;
            end
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skt_pkg::S_IDLE;
         result_ff    <= skt_pkg::ST_OK;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         result_ff    <= result_in;
         zero_ff      <= zero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/sorted_key_table.sv @@
// Sorted key table: top level joining the command sequencer and the entry datapath.
//
// req_chan carries one command beat (cmd, part_number, name_word, amount);
// rsp_chan carries result beats (status, out_number, out_name, out_quantity,
// last). Beats move on a rising edge with valid and ready both high.
// Entries stay sorted ascending by part number in a row of TABLE_DEPTH cells.
// Insert, search and update: one result beat; every cell compares its key
// at once, the slot is taken from the compare thermometer, the cells shift
// or the quantity takes its saturating add, then the result loads. The next
// command is taken only after the load.
// List: beats follow the command beat at one beat per cycle while the
// receiver takes them, last set on the final entry; an empty table gives
// one beat with the empty status. A list holds off the next command until
// its last beat has loaded.
// When rsp_chan.ready is low the result register holds its beat and the
// sequencer waits; no beat is dropped or repeated.
// Reset (synchronous, active high) empties the table and drops any pending
// result; stored entries are not cleared, only the entry count.
`default_nettype none

module sorted_key_table #(
   parameter int TABLE_DEPTH = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   skt_req_if.sink     req_chan,
   skt_rsp_if.source   rsp_chan
);

   skt_pkg::ctrl_type      ctrl;
   skt_pkg::dp_status_type dp_status;
   skt_pkg::dp_status_type seq_status;
   logic                   req_ready;
   logic                   rsp_valid;

   // At the accept edge the sequencer decodes the command straight from the port;
   // afterwards it follows the latched copy in the datapath.
   always_comb begin
      seq_status = dp_status;
      if (req_ready) begin
         seq_status.cmd = req_chan.cmd;
      end
   end

   skt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .dp_status (seq_status),
      .ctrl      (ctrl)
   );

   skt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_chan.cmd),
      .req_part_number  (req_chan.part_number),
      .req_name_word    (req_chan.name_word),
      .req_amount       (req_chan.amount),
      .ctrl             (ctrl),
      .dp_status        (dp_status),
      .rsp_status       (rsp_chan.status),
      .rsp_out_number   (rsp_chan.out_number),
      .rsp_out_name     (rsp_chan.out_name),
      .rsp_out_quantity (rsp_chan.out_quantity),
      .rsp_last         (rsp_chan.last)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

endmodule

`default_nettype wire

@@ tb/sv/sorted_key_table_tb.sv @@
// Self-checking regression bench for the sorted key table.
module sorted_key_table_tb;
   import skt_pkg::*;

   localparam int TABLE_DEPTH = 32;
   localparam int QUIET_LIMIT = 2000;   // cycles with no beat on either channel
   localparam int SETTLE_CYCLES = 60;   // longest list plus pipeline, with margin
   localparam logic [KEY_W-1:0] KEY_MAX = 31'h7FFF_FFFF;
   localparam logic [KEY_W-1:0] KEY_MID = 31'h4000_0000;
   localparam logic signed [QTY_W-1:0] QTY_MAX = 32'h7FFF_FFFF;
   localparam logic signed [QTY_W-1:0] QTY_MIN = 32'h8000_0000;

   typedef struct {
      status_type                status;
      logic [KEY_W-1:0]          number;
      logic [NAME_W-1:0]         name;
      logic signed [QTY_W-1:0]   quantity;
      logic                      last;
   } table_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   skt_req_if req_chan ();
   skt_rsp_if rsp_chan ();

   sorted_key_table #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the table: keys ascending, valid below shadow_count.
   logic [KEY_W-1:0]        shadow_key [TABLE_DEPTH];
   logic [NAME_W-1:0]       shadow_name [TABLE_DEPTH];
   logic signed [QTY_W-1:0] shadow_qty [TABLE_DEPTH];
   int                      shadow_count = 0;

   // Result beats the block still owes, oldest first.
   table_result_t pending_results [$];

   int mismatches = 0;
   int commands_sent = 0;
   int beats_checked = 0;
   int status_seen [5] = '{default: 0};
   int longest_list = 0;

   // Idle controls shared by the stimulus and the result sink.
   int req_gap_max = 11;
   int rsp_gap_max = 11;
   int rsp_hold_cycles = 0;
   int quiet_cycles = 0;

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Queue one result beat; a negative slot reports an all-zero entry.
   function automatic void push_result(status_type st, int slot, logic last);
      table_result_t r;
      r.status = st;
      r.last   = last;
      if (slot < 0) begin
         r.number   = '0;
         r.name     = '0;
         r.quantity = '0;
      end else begin
         r.number   = shadow_key[slot];
         r.name     = shadow_name[slot];
         r.quantity = shadow_qty[slot];
      end
      pending_results.push_back(r);
   endfunction

   // Apply one accepted command to the shadow table and queue its results.
   function automatic void shadow_execute(cmd_type cmd, logic [KEY_W-1:0] key,
         logic [NAME_W-1:0] name, logic signed [QTY_W-1:0] amt);
      int slot;
      bit hit;
      logic [QTY_W:0] sum;
      slot = 0;
      if (cmd == CMD_LIST) begin
         // Empty table answers with a single empty status; otherwise
         // stream every entry from the lowest key, last on the final one.
         if (shadow_count == 0) begin
            push_result(ST_EMPTY, -1, 1'b1);
         end else begin
            for (int i = 0; i < shadow_count; i++)
               push_result(ST_OK, i, i == shadow_count - 1);
            if (shadow_count > longest_list) longest_list = shadow_count;
         end
         return;
      end
      // Locate the first slot whose key is not below the command key.
      while (slot < shadow_count && shadow_key[slot] < key) slot++;
      hit = slot < shadow_count && shadow_key[slot] == key;
      case (cmd)
         CMD_INSERT: begin
            // A full table rejects before the duplicate test is made.
            if (shadow_count >= TABLE_DEPTH) begin
               push_result(ST_FULL, -1, 1'b1);
            end else if (hit) begin
               push_result(ST_DUPLICATE, slot, 1'b1);
            end else begin
               for (int j = shadow_count; j > slot; j--) begin
                  shadow_key[j]  = shadow_key[j-1];
                  shadow_name[j] = shadow_name[j-1];
                  shadow_qty[j]  = shadow_qty[j-1];
               end
               shadow_key[slot]  = key;
               shadow_name[slot] = name;
               shadow_qty[slot]  = amt;
               shadow_count++;
               push_result(ST_OK, slot, 1'b1);
            end
         end
         CMD_SEARCH: begin
            if (hit) push_result(ST_OK, slot, 1'b1);
            else push_result(ST_NOT_FOUND, -1, 1'b1);
         end
         default: begin
            if (!hit) begin
               push_result(ST_NOT_FOUND, -1, 1'b1);
            end else begin
               // Add in 33 bits; a sign change between the top two bits
               // means overflow, so clamp to the signed limit.
               sum = {shadow_qty[slot][QTY_W-1], shadow_qty[slot]} + {amt[QTY_W-1], amt};
               if (sum[QTY_W] != sum[QTY_W-1])
                  shadow_qty[slot] = sum[QTY_W] ? QTY_MIN : QTY_MAX;
               else
                  shadow_qty[slot] = sum[QTY_W-1:0];
               push_result(ST_OK, slot, 1'b1);
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Random field helpers
   // ---------------------------------------------------------------------

   function automatic logic [KEY_W-1:0] fresh_key();
      logic [31:0] r;
      r = $urandom();
      return r[KEY_W-1:0];
   endfunction

   function automatic logic [KEY_W-1:0] stored_key();
      if (shadow_count == 0) return fresh_key();
      return shadow_key[$urandom_range(0, shadow_count - 1)];
   endfunction

   // Mostly keys already in the table, the rest almost always misses.
   function automatic logic [KEY_W-1:0] probe_key();
      if ($urandom_range(0, 99) < 80) return stored_key();
      return fresh_key();
   endfunction

   function automatic logic [NAME_W-1:0] random_name();
      return {$urandom(), $urandom()};
   endfunction

   // Mix full-range values, small changes and values near the limits.
   function automatic logic signed [QTY_W-1:0] random_amount();
      case ($urandom_range(0, 3))
         0, 1: return $urandom();
         2: return $signed($urandom_range(0, 2000)) - 1000;
         default: begin
            case ($urandom_range(0, 3))
               0: return QTY_MAX;
               1: return QTY_MIN;
               2: return QTY_MAX - $urandom_range(0, 3);
               default: return QTY_MIN + $urandom_range(0, 3);
            endcase
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Command side
   // ---------------------------------------------------------------------

   // Offer one command beat after a random gap and hold it until taken.
   // Keep valid high across back-to-back beats; lower it only for a gap.
   task automatic send_command(input cmd_type cmd, input logic [KEY_W-1:0] key,
         input logic [NAME_W-1:0] name, input logic signed [QTY_W-1:0] amt);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.cmd         <= cmd;
      req_chan.part_number <= key;
      req_chan.name_word   <= name;
      req_chan.amount      <= amt;
      @(posedge clock);
      while (!(req_chan.valid && req_chan.ready)) @(posedge clock);
      shadow_execute(cmd, key, name, amt);
      commands_sent++;
   endtask

   // Stop offering and hold until every owed result beat has come back.
   task automatic await_all_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------

   task automatic check_result();
      table_result_t want;
      beats_checked++;
      if (pending_results.size() == 0) begin
         $error("result beat with nothing owed: status %0d number %0h",
                rsp_chan.status, rsp_chan.out_number);
         mismatches++;
         return;
      end
      want = pending_results.pop_front();
      status_seen[want.status]++;
      if (rsp_chan.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
         mismatches++;
      end
      if (rsp_chan.out_number !== want.number) begin
         $error("out_number: expected %0h, got %0h", want.number, rsp_chan.out_number);
         mismatches++;
      end
      if (rsp_chan.out_name !== want.name) begin
         $error("out_name: expected %0h, got %0h", want.name, rsp_chan.out_name);
         mismatches++;
      end
      if (rsp_chan.out_quantity !== want.quantity) begin
         $error("out_quantity: expected %0d, got %0d", want.quantity, rsp_chan.out_quantity);
         mismatches++;
      end
      if (rsp_chan.last !== want.last) begin
         $error("last: expected %0b, got %0b", want.last, rsp_chan.last);
         mismatches++;
      end
   endtask

   // Result sink: stall a random number of cycles before each beat, and
   // honor a long hold-off when a test asks for one.
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(0, rsp_gap_max);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_chan.valid && rsp_chan.ready)) begin
            if (rsp_hold_cycles > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (rsp_hold_cycles) @(posedge clock);
               rsp_hold_cycles = 0;
               rsp_chan.ready <= 1'b1;
            end
            @(posedge clock);
         end
         check_result();
      end
   end

   // Watchdog: end the run if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no beat moved for %0d cycles, %0d results still owed",
                     QUIET_LIMIT, pending_results.size());
            $display("sorted_key_table regression: fail");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Commands on a freshly reset table: empty list, misses on both ends.
   task automatic test_empty_table();
      send_command(CMD_LIST, '0, '0, '0);
      send_command(CMD_SEARCH, '0, random_name(), random_amount());
      send_command(CMD_UPDATE, KEY_MAX, random_name(), QTY_MAX);
   endtask

   // Build a small table out of order, hit a duplicate, read both ends.
   task automatic test_insert_order();
      send_command(CMD_INSERT, KEY_MID, 64'hA5A5_5A5A_0F0F_F0F0, 32'sd100);
      send_command(CMD_INSERT, '0, '0, QTY_MIN);
      send_command(CMD_INSERT, KEY_MAX, '1, QTY_MAX);
      send_command(CMD_INSERT, 31'd1, 64'h8000_0000_0000_0001, -32'sd1);
      send_command(CMD_INSERT, KEY_MID, 64'h1234_5678_9ABC_DEF0, 32'sd7);
      send_command(CMD_SEARCH, '0, random_name(), random_amount());
      send_command(CMD_SEARCH, KEY_MAX, random_name(), random_amount());
      send_command(CMD_LIST, KEY_MID, random_name(), random_amount());
   endtask

   // Drive quantities into both limits and back out of them.
   task automatic test_quantity_saturation();
      send_command(CMD_UPDATE, KEY_MAX, random_name(), 32'sd1);
      send_command(CMD_UPDATE, '0, random_name(), -32'sd1);
      send_command(CMD_UPDATE, 31'd1, random_name(), QTY_MIN);
      send_command(CMD_UPDATE, KEY_MID, random_name(), QTY_MAX);
      send_command(CMD_UPDATE, '0, random_name(), QTY_MAX);
      send_command(CMD_LIST, '0, '0, '0);
   endtask

   // Keys that fall between stored ones or next to the top key.
   task automatic test_missing_keys();
      send_command(CMD_SEARCH, 31'd2, random_name(), random_amount());
      send_command(CMD_UPDATE, 31'h3FFF_FFFF, random_name(), 32'sd5);
      send_command(CMD_SEARCH, KEY_MAX - 31'd1, random_name(), random_amount());
   endtask

   // Mixed traffic: mostly hits on stored keys, some misses, duplicates,
   // neighbors of stored keys and full lists, so the table fills gradually.
   task automatic test_random_traffic(input int n_cmds);
      int pick;
      logic [KEY_W-1:0] key;
      for (int i = 0; i < n_cmds; i++) begin
         // Run a stretch with no idling on either side.
         if (i == n_cmds / 3) begin
            req_gap_max = 0;
            rsp_gap_max = 0;
         end
         if (i == n_cmds / 3 + 40) begin
            req_gap_max = 11;
            rsp_gap_max = 11;
         end
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            case ($urandom_range(0, 3))
               0, 1: key = fresh_key();
               2: key = stored_key() + ($urandom_range(0, 1) ? 31'd1 : -31'd1);
               default: key = stored_key();
            endcase
            send_command(CMD_INSERT, key, random_name(), random_amount());
         end else if (pick < 50) begin
            send_command(CMD_SEARCH, probe_key(), random_name(), random_amount());
         end else if (pick < 88) begin
            send_command(CMD_UPDATE, probe_key(), random_name(), random_amount());
         end else begin
            send_command(CMD_LIST, fresh_key(), random_name(), random_amount());
         end
      end
   endtask

   // Hold the result side off while commands keep coming, so the result
   // register fills and the block stops taking commands.
   task automatic test_receiver_backpressure();
      await_all_results();
      rsp_hold_cycles = 150;
      req_gap_max = 0;
      send_command(CMD_LIST, '0, '0, '0);
      send_command(CMD_SEARCH, stored_key(), random_name(), random_amount());
      send_command(CMD_UPDATE, stored_key(), random_name(), random_amount());
      send_command(CMD_INSERT, fresh_key(), random_name(), random_amount());
      send_command(CMD_SEARCH, fresh_key(), random_name(), random_amount());
      send_command(CMD_LIST, '0, '0, '0);
      req_gap_max = 11;
   endtask

   // Pause until the table is quiet, top it up to capacity, then check
   // the full rejects (ahead of the duplicate test) and the longest list.
   task automatic test_full_table();
      await_all_results();
      while (shadow_count < TABLE_DEPTH)
         send_command(CMD_INSERT, fresh_key(), random_name(), random_amount());
      send_command(CMD_INSERT, fresh_key(), random_name(), random_amount());
      send_command(CMD_INSERT, stored_key(), random_name(), random_amount());
      send_command(CMD_LIST, '0, '0, '0);
      send_command(CMD_UPDATE, stored_key(), random_name(), QTY_MIN);
      send_command(CMD_SEARCH, stored_key(), random_name(), random_amount());
      rsp_gap_max = 0;
      send_command(CMD_LIST, '0, '0, '0);
      await_all_results();
      rsp_gap_max = 11;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      req_chan.valid       <= 1'b0;
      req_chan.cmd         <= CMD_INSERT;
      req_chan.part_number <= '0;
      req_chan.name_word   <= '0;
      req_chan.amount      <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_insert_order();
      test_quantity_saturation();
      test_missing_keys();
      test_random_traffic(300);
      test_receiver_backpressure();
      test_full_table();

      // Drain, then let the block sit to catch any stray beat.
      await_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d result beats never arrived", pending_results.size());
         mismatches++;
      end

      $display("ran %0d commands, checked %0d result beats, longest list %0d of %0d entries",
               commands_sent, beats_checked, longest_list, TABLE_DEPTH);
      $display("status counts: ok %0d, duplicate %0d, not found %0d, full %0d, empty %0d",
               status_seen[ST_OK], status_seen[ST_DUPLICATE], status_seen[ST_NOT_FOUND],
               status_seen[ST_FULL], status_seen[ST_EMPTY]);
      if (mismatches == 0)
         $display("sorted_key_table regression: pass");
      else
         $display("sorted_key_table regression: fail");
      $finish;
   end

endmodule
